// ===== hw/rtl/bounded_stack_search_min_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bounded stack
// Shared concurrent assertion forms, compiled out under NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_STACK_SEARCH_MIN_MACROS_SVH
`define BOUNDED_STACK_SEARCH_MIN_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BSSM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bssm: assertion failed");

// next-cycle implication
`define BSSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bssm: assertion failed");

`else

`define BSSM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BSSM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/bssm_pkg.sv =====
// ----------------------------------------------------------------------------
// bssm_pkg
// Types, sizes and codes of the bounded stack with search and minimum.
// ----------------------------------------------------------------------------
`default_nettype none

package bssm_pkg;

    localparam int DEPTH    = 16;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int ITEM_W   = 5;

    localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SEARCH  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MIN     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_REVERSE = 3'd5;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd6;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;

    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] data_value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [STATUS_W-1:0]      status;
        logic                     found;
        logic [ITEM_W-1:0]        item_count;
        logic                     is_empty;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_REV_HI,
        ST_REV_LO,
        ST_REV_UP
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bssm_ram.sv =====
// ----------------------------------------------------------------------------
// bssm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bssm_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bounded_stack_search_min.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_search_min
// Fixed-depth stack of signed words: push, pop, peek, search, minimum,
// reverse and clear, one result per request.
//
//   channel | signals                      | direction
//   --------+------------------------------+----------
//   request | req_valid, req_ready, req    | in
//   result  | rsp_valid, rsp_ready, rsp    | out
//
// Push, clear, unused kinds, empty-stack cases and reverse below two entries:
// answered from the idle state. Pop and peek: one read state (registered RAM read).
// Search and minimum: one entry per cycle through one compare.
// Reverse: a read state, then a low-write and a high-write state per pair of
// entries, bound by the single RAM write port.
// Reset clears the state, the count and the result valid; entries are undefined until written.
// A new request is taken once idle and the result register is free or draining.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_stack_search_min_macros.svh"

module bounded_stack_search_min (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire bssm_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output bssm_pkg::rsp_t     rsp
);

    import bssm_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;

    logic [PTR_W-1:0] pos_reg, pos_next;
    logic [PTR_W-1:0] lo_reg, lo_next;
    logic [PTR_W-1:0] hi_reg, hi_next;
    logic [DATA_W-1:0] tmp_reg, tmp_next;
    logic signed [DATA_W-1:0] acc_reg, acc_next;
    logic found_reg, found_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [DATA_W-1:0] value_reg, value_next;

    logic accept;
    logic cnt_zero, cnt_full, cnt_small;
    logic [PTR_W-1:0] top_ptr, lo_plus, hi_minus;
    logic scan_last, rev_more, rev_step;
    logic cmp_lt, cmp_eq, take;
    logic signed [DATA_W-1:0] acc_cur;
    logic found_cur;

    logic ram_we;
    logic [PTR_W-1:0] ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    logic rsp_load;
    logic signed [DATA_W-1:0] res_value;
    logic [STATUS_W-1:0] res_status;
    logic res_found;

    bssm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign cnt_zero  = (count_reg == '0);
    assign cnt_full  = (count_reg == CNT_W'(DEPTH));
    assign cnt_small = (count_reg < CNT_W'(2));
    assign top_ptr   = PTR_W'(count_reg - CNT_W'(1));
    assign lo_plus   = lo_reg + PTR_W'(1);
    assign hi_minus  = hi_reg - PTR_W'(1);
    assign scan_last = ((CNT_W'(pos_reg) + CNT_W'(1)) == count_reg);
    assign rev_more  = (lo_plus < hi_minus);
    assign rev_step  = (state_reg == ST_REV_LO) || (state_reg == ST_REV_UP);

    // shared compare unit
    assign cmp_lt    = $signed(ram_rdata) < acc_reg;
    assign cmp_eq    = (ram_rdata == value_reg);
    assign take      = (pos_reg == '0) || cmp_lt;
    assign acc_cur   = take ? $signed(ram_rdata) : acc_reg;
    assign found_cur = found_reg || cmp_eq;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((req.kind == KIND_POP || req.kind == KIND_PEEK) && !cnt_zero)
                    begin
                        state_next = ST_READ;
                    end
                    else if ((req.kind == KIND_SEARCH || req.kind == KIND_MIN) && !cnt_zero)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (req.kind == KIND_REVERSE && !cnt_small)
                    begin
                        state_next = ST_REV_HI;
                    end
                end
            end
            ST_READ:   state_next = ST_IDLE;
            ST_SCAN:   state_next = scan_last ? ST_IDLE : ST_SCAN;
            ST_REV_HI: state_next = ST_REV_LO;
            ST_REV_LO: state_next = ST_REV_UP;
            ST_REV_UP: state_next = rev_more ? ST_REV_LO : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        pos_next   = pos_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        tmp_next   = tmp_reg;
        acc_next   = acc_reg;
        found_next = found_reg;
        kind_next  = kind_reg;
        value_next = value_reg;
        ram_we     = 1'b0;
        ram_waddr  = lo_reg;
        ram_wdata  = ram_rdata;
        ram_raddr  = pos_reg;
        rsp_load   = 1'b0;
        res_value  = '0;
        res_status = STATUS_OK;
        res_found  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = (req.kind == KIND_POP || req.kind == KIND_PEEK) ? top_ptr : '0;
                if (accept)
                begin
                    kind_next  = req.kind;
                    value_next = req.data_value;
                    pos_next   = '0;
                    lo_next    = '0;
                    hi_next    = top_ptr;
                    found_next = 1'b0;
                    unique case (req.kind)
                        KIND_PUSH:
                        begin
                            rsp_load = 1'b1;
                            if (cnt_full)
                            begin
                                res_status = STATUS_OVERFLOW;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = PTR_W'(count_reg);
                                ram_wdata  = req.data_value;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_POP, KIND_PEEK:
                        begin
                            if (cnt_zero)
                            begin
                                rsp_load   = 1'b1;
                                res_value  = EMPTY_VALUE;
                                res_status = STATUS_EMPTY;
                            end
                            else if (req.kind == KIND_POP)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        KIND_SEARCH:
                        begin
                            rsp_load = cnt_zero;
                        end
                        KIND_MIN:
                        begin
                            if (cnt_zero)
                            begin
                                rsp_load   = 1'b1;
                                res_value  = EMPTY_VALUE;
                                res_status = STATUS_EMPTY;
                            end
                        end
                        KIND_REVERSE:
                        begin
                            rsp_load = cnt_small;
                        end
                        KIND_CLEAR:
                        begin
                            rsp_load   = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            rsp_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                rsp_load  = 1'b1;
                res_value = $signed(ram_rdata);
            end
            ST_SCAN:
            begin
                ram_raddr  = pos_reg + PTR_W'(1);
                pos_next   = pos_reg + PTR_W'(1);
                acc_next   = acc_cur;
                found_next = found_cur;
                if (scan_last)
                begin
                    rsp_load  = 1'b1;
                    res_value = (kind_reg == KIND_MIN) ? acc_cur : '0;
                    res_found = (kind_reg == KIND_SEARCH) && found_cur;
                end
            end
            ST_REV_HI:
            begin
                tmp_next  = ram_rdata;
                ram_raddr = hi_reg;
            end
            ST_REV_LO:
            begin
                ram_we    = 1'b1;
                ram_waddr = lo_reg;
                ram_wdata = ram_rdata;
                ram_raddr = lo_plus;
            end
            ST_REV_UP:
            begin
                ram_we    = 1'b1;
                ram_waddr = hi_reg;
                ram_wdata = tmp_reg;
                tmp_next  = ram_rdata;
                ram_raddr = hi_minus;
                lo_next   = lo_plus;
                hi_next   = hi_minus;
                rsp_load  = !rev_more;
            end
            default:
            begin
                rsp_load = 1'b0;
            end
        endcase

        rsp_next.result_value = res_value;
        rsp_next.status       = res_status;
        rsp_next.found        = res_found;
        rsp_next.item_count   = ITEM_W'(count_next);
        rsp_next.is_empty     = (count_next == '0);

        rsp_valid_next = rsp_load ? 1'b1 : (rsp_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        tmp_reg   <= tmp_next;
        acc_reg   <= acc_next;
        found_reg <= found_next;
        kind_reg  <= kind_next;
        value_reg <= value_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    `BSSM_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `BSSM_ASSERT_IMPL(a_load_free, clk, rst_n, rsp_load, !rsp_valid_reg || rsp_ready)
    `BSSM_ASSERT_IMPL(a_busy_no_rsp, clk, rst_n, state_reg != ST_IDLE, !rsp_valid_reg)
    `BSSM_ASSERT_IMPL(a_busy_count, clk, rst_n, state_reg != ST_IDLE, count_next == count_reg)
    `BSSM_ASSERT_IMPL(a_rev_order, clk, rst_n, rev_step, lo_reg < hi_reg)
    `BSSM_ASSERT_NEXT(a_load_valid, clk, rst_n, rsp_load, rsp_valid_reg)

endmodule

`default_nettype wire

// ===== tb/bounded_stack_search_min_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_search_min_tb
// Self-checking bench for the bounded stack. A shadow stack predicts every
// response; the checker compares each transfer on the response channel with
// the oldest prediction. Directed cases cover the empty and full stack and the
// word extremes. Random traffic alternates fill and drain bias under four
// handshake pressure profiles.
// ----------------------------------------------------------------------------
module bounded_stack_search_min_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bssm_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   req_valid = 1'b0;
    logic   req_ready;
    req_t   req       = '0;
    logic   rsp_valid;
    logic   rsp_ready = 1'b0;
    rsp_t   rsp;

    logic signed [DATA_W-1:0] shadow_mem [DEPTH];
    int     shadow_cnt = 0;
    rsp_t   pending_rsp_q [$];

    int     idle_pct      = 0;
    int     stall_pct     = 0;
    int     fail_count    = 0;
    int     req_count     = 0;
    int     rsp_count     = 0;
    int     overflow_seen = 0;
    int     empty_seen    = 0;
    int     hit_seen      = 0;
    int     kind_seen [8] = '{default: 0};

    bounded_stack_search_min dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic rsp_t predict_stack(input req_t r);
        rsp_t                     o;
        logic signed [DATA_W-1:0] tmp;
        int                       i;
        o = '0;
        case (r.kind)
            KIND_PUSH:
            begin
                if (shadow_cnt >= DEPTH)
                    o.status = STATUS_OVERFLOW;
                else
                begin
                    shadow_mem[shadow_cnt] = r.data_value;
                    shadow_cnt++;
                end
            end
            KIND_POP, KIND_PEEK:
            begin
                if (shadow_cnt == 0)
                begin
                    o.result_value = EMPTY_VALUE;
                    o.status       = STATUS_EMPTY;
                end
                else
                begin
                    o.result_value = shadow_mem[shadow_cnt - 1];
                    if (r.kind == KIND_POP)
                        shadow_cnt--;
                end
            end
            KIND_SEARCH:
            begin
                for (i = 0; i < shadow_cnt; i++)
                    if (shadow_mem[i] == r.data_value)
                        o.found = 1'b1;
            end
            KIND_MIN:
            begin
                if (shadow_cnt == 0)
                begin
                    o.result_value = EMPTY_VALUE;
                    o.status       = STATUS_EMPTY;
                end
                else
                begin
                    o.result_value = shadow_mem[0];
                    for (i = 1; i < shadow_cnt; i++)
                        if (shadow_mem[i] < o.result_value)
                            o.result_value = shadow_mem[i];
                end
            end
            KIND_REVERSE:
            begin
                for (i = 0; i < shadow_cnt / 2; i++)
                begin
                    tmp                            = shadow_mem[i];
                    shadow_mem[i]                  = shadow_mem[shadow_cnt - 1 - i];
                    shadow_mem[shadow_cnt - 1 - i] = tmp;
                end
            end
            KIND_CLEAR:
                shadow_cnt = 0;
            default:
                ;
        endcase
        o.item_count = ITEM_W'(shadow_cnt);
        o.is_empty   = (shadow_cnt == 0);
        return o;
    endfunction

    function automatic logic signed [DATA_W-1:0] random_word();
        case ($urandom_range(7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            3:       return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic signed [DATA_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid      = 1'b1;
        req.kind       = kind;
        req.data_value = value;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_rsp_q.push_back(predict_stack(req));
        req_count++;
        kind_seen[kind]++;
    endtask

    task automatic test_empty_stack();
        send_request(KIND_POP, 32'sd0);
        send_request(KIND_PEEK, 32'sd0);
        send_request(KIND_MIN, 32'sd0);
        send_request(KIND_SEARCH, -32'sd1);
        send_request(KIND_REVERSE, 32'sd0);
        send_request(KIND_CLEAR, 32'sd0);
        send_request(KIND_UNUSED, -32'sd1);
    endtask

    task automatic test_value_extremes();
        send_request(KIND_PUSH, 32'sh7fff_ffff);
        send_request(KIND_REVERSE, 32'sd0);
        send_request(KIND_PEEK, 32'sd0);
        send_request(KIND_PUSH, 32'sh8000_0000);
        send_request(KIND_PUSH, -32'sd1);
        send_request(KIND_PUSH, 32'sd0);
        send_request(KIND_MIN, 32'sd0);
        send_request(KIND_SEARCH, -32'sd1);
        send_request(KIND_SEARCH, 32'sh1234_5678);
        send_request(KIND_SEARCH, 32'sh8000_0000);
        send_request(KIND_REVERSE, 32'sd0);
        send_request(KIND_UNUSED, 32'sh5555_aaaa);
        send_request(KIND_POP, 32'sd0);
        send_request(KIND_POP, 32'sd0);
        send_request(KIND_PEEK, 32'sd0);
    endtask

    task automatic test_full_stack();
        int i;
        send_request(KIND_CLEAR, 32'sd0);
        for (i = 0; i < DEPTH; i++)
            send_request(KIND_PUSH, (i % 2) ? -(i * 1000) : i * 7919);
        send_request(KIND_PUSH, 32'sh7fff_ffff);
        send_request(KIND_MIN, 32'sd0);
        send_request(KIND_REVERSE, 32'sd0);
        send_request(KIND_PEEK, 32'sd0);
        send_request(KIND_SEARCH, -32'sd15000);
        send_request(KIND_CLEAR, 32'sd0);
        send_request(KIND_POP, 32'sd0);
        send_request(KIND_PUSH, 32'sd42);
        send_request(KIND_PEEK, 32'sd0);
    endtask

    task automatic test_random_traffic(input int n, input int idle, input int stall);
        int                       k;
        int                       push_pct;
        int                       roll;
        bit                       filling;
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
        idle_pct  = idle;
        stall_pct = stall;
        filling   = 1'b1;
        for (k = 0; k < n; k++)
        begin
            if (k % 40 == 39)
                filling = !filling;
            push_pct = filling ? 55 : 20;
            if ($urandom_range(99) < push_pct)
                kind = KIND_PUSH;
            else
            begin
                roll = $urandom_range(99);
                if (roll < 32)
                    kind = KIND_POP;
                else if (roll < 44)
                    kind = KIND_PEEK;
                else if (roll < 62)
                    kind = KIND_SEARCH;
                else if (roll < 78)
                    kind = KIND_MIN;
                else if (roll < 93)
                    kind = KIND_REVERSE;
                else if (roll < 96)
                    kind = KIND_CLEAR;
                else
                    kind = KIND_UNUSED;
            end
            if (kind == KIND_SEARCH && shadow_cnt > 0 && $urandom_range(1))
                value = shadow_mem[$urandom_range(shadow_cnt - 1)];
            else
                value = random_word();
            send_request(kind, value);
        end
    endtask

    always @(negedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rsp_count++;
            if (rsp.status == STATUS_OVERFLOW)
                overflow_seen++;
            if (rsp.status == STATUS_EMPTY)
                empty_seen++;
            if (rsp.found)
                hit_seen++;
            if (pending_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected transfer: value %0d status %0d found %0b count %0d empty %0b",
                         $time, rsp.result_value, rsp.status, rsp.found,
                         rsp.item_count, rsp.is_empty);
                fail_count++;
            end
            else
            begin
                want = pending_rsp_q.pop_front();
                if (rsp.result_value !== want.result_value || rsp.status !== want.status ||
                    rsp.found !== want.found || rsp.item_count !== want.item_count ||
                    rsp.is_empty !== want.is_empty)
                begin
                    $display("%0t: mismatch: expected value %0d status %0d found %0b count %0d empty %0b",
                             $time, want.result_value, want.status, want.found,
                             want.item_count, want.is_empty);
                    $display("%0t:           actual value %0d status %0d found %0b count %0d empty %0b",
                             $time, rsp.result_value, rsp.status, rsp.found,
                             rsp.item_count, rsp.is_empty);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles, %0d responses outstanding",
                 $time, STALL_LIMIT, pending_rsp_q.size());
        $display("bounded_stack_search_min test failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_stack();
        test_value_extremes();
        test_full_stack();
        test_random_traffic(150, 0, 0);
        test_random_traffic(150, 78, 0);
        test_random_traffic(150, 0, 78);
        test_random_traffic(150, 15, 15);

        @(negedge clk);
        req_valid = 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests, %0d responses: push %0d pop %0d peek %0d search %0d min %0d reverse %0d clear %0d unused %0d",
                 req_count, rsp_count, kind_seen[0], kind_seen[1], kind_seen[2],
                 kind_seen[3], kind_seen[4], kind_seen[5], kind_seen[6], kind_seen[7]);
        $display("Overflows %0d, empty-stack reads %0d, search hits %0d, mismatches %0d",
                 overflow_seen, empty_seen, hit_seen, fail_count);
        if (fail_count == 0)
            $display("bounded_stack_search_min test passed");
        else
            $display("bounded_stack_search_min test failed");
        $finish;
    end

endmodule
